@@ hdl/prtq_pkg.sv @@
// ---------------------------------------------------------------------------
// prtq_pkg
// Shared types and codes of the pending request timeout queue.
// ---------------------------------------------------------------------------
`default_nettype none

package prtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_WAKE = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [1:0] OUT_RELEASED = 2'd0;
  localparam logic [1:0] OUT_TIMEDOUT = 2'd1;
  localparam logic [1:0] OUT_REJECTED = 2'd2;

  localparam logic [1:0]  ADDR_TIMEOUT  = 2'd0;
  localparam logic [31:0] TIMEOUT_RESET = 32'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [31:0] now;
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/prtq_ifs.sv @@
// ---------------------------------------------------------------------------
// prtq_ifs
// Request and result channel interfaces with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface prtq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] task_id;
  logic [31:0] now_time;

  modport source (output valid, output req_type, output task_id, output now_time,
                  input ready);
  modport sink (input valid, input req_type, input task_id, input now_time,
                output ready);
endinterface

interface prtq_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_task;
  logic [1:0]  outcome;
  logic        last_of_run;

  modport source (output valid, output out_task, output outcome, output last_of_run,
                  input ready);
  modport sink (input valid, input out_task, input outcome, input last_of_run,
                output ready);
endinterface

`default_nettype wire

@@ hdl/prtq_front.sv @@
// ---------------------------------------------------------------------------
// prtq_front
// Accepts requests, drops unused codes and buffers commands in a
// two-entry queue toward the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module prtq_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  prtq_in_if.sink            in_ch,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output prtq_pkg::cmd_t     cmd
);

  prtq_pkg::cmd_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept, known, push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign accept = in_ch.valid && in_ch.ready;
  assign known = (in_ch.req_type == prtq_pkg::REQ_ADD) ||
                 (in_ch.req_type == prtq_pkg::REQ_WAKE) ||
                 (in_ch.req_type == prtq_pkg::REQ_TICK);
  assign push = accept && known;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{kind: in_ch.req_type, id: in_ch.task_id, now: in_ch.now_time};
    end
  end

endmodule

`default_nettype wire

@@ hdl/prtq_back.sv @@
// ---------------------------------------------------------------------------
// prtq_back
// Holds the ordered entry store and executes add, wakeup and tick
// commands, walking the store one entry per cycle unless the result channel stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module prtq_back #(
  parameter int QUEUE_DEPTH = prtq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire prtq_pkg::cmd_t cmd,
  input  wire logic [31:0]    timeout_limit,
  prtq_out_if.source          out_ch
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  logic [15:0] ids_mem [QUEUE_DEPTH];
  logic [31:0] stamps_mem [QUEUE_DEPTH];

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] walk_cnt_r, walk_cnt_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic          v_r, v_nxt;
  logic          is_tick_r, is_tick_nxt;
  logic [31:0]   now_r, now_nxt;
  logic          hold_v_r, hold_v_nxt;
  logic [15:0]   hold_id_r, hold_id_nxt;
  logic [1:0]    hold_code_r, hold_code_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_task_r, out_task_nxt;
  logic [1:0]    out_code_r, out_code_nxt;
  logic          out_last_r, out_last_nxt;

  logic [15:0]   rd_id_r;
  logic [31:0]   rd_stamp_r;

  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [15:0]   wid;
  logic [31:0]   wstamp;

  logic          out_space, expired, produce, done_read, stall, take;
  logic          push;
  logic [15:0]   push_id;
  logic [1:0]    push_code;
  logic          push_last;
  logic [31:0]   age;

  assign out_space = !out_valid_r || out_ch.ready;
  assign age = now_r - rd_stamp_r;
  assign expired = is_tick_r ? (age > timeout_limit) : 1'b1;
  assign produce = v_r && expired;
  assign done_read = (rd_idx_r == walk_cnt_r);

  assign cmd_ready = (state_r == ST_IDLE) &&
                     ((cmd.kind != prtq_pkg::REQ_ADD) || (count_r < DEPTH_C) || out_space);
  assign take = cmd_valid && cmd_ready;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    walk_cnt_nxt = walk_cnt_r;
    rd_idx_nxt = rd_idx_r;
    kept_nxt = kept_r;
    v_nxt = v_r;
    is_tick_nxt = is_tick_r;
    now_nxt = now_r;
    hold_v_nxt = hold_v_r;
    hold_id_nxt = hold_id_r;
    hold_code_nxt = hold_code_r;
    we = 1'b0;
    waddr = count_r[IW-1:0];
    wid = cmd.id;
    wstamp = cmd.now;
    re = 1'b0;
    raddr = rd_idx_r[IW-1:0];
    push = 1'b0;
    push_id = hold_id_r;
    push_code = hold_code_r;
    push_last = 1'b0;
    stall = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (cmd.kind == prtq_pkg::REQ_ADD) begin
            if (count_r < DEPTH_C) begin
              we = 1'b1;
              count_nxt = count_r + CW'(1);
            end else begin
              push = 1'b1;
              push_id = cmd.id;
              push_code = prtq_pkg::OUT_REJECTED;
              push_last = 1'b1;
            end
          end else if (count_r != '0) begin
            state_nxt = ST_WALK;
            walk_cnt_nxt = count_r;
            rd_idx_nxt = '0;
            kept_nxt = '0;
            v_nxt = 1'b0;
            is_tick_nxt = (cmd.kind == prtq_pkg::REQ_TICK);
            now_nxt = cmd.now;
          end
        end
      end
      ST_WALK: begin
        if (v_r) begin
          stall = produce && hold_v_r && !out_space;
        end else if (done_read) begin
          stall = hold_v_r && !out_space;
        end
        if (!stall) begin
          if (v_r || !done_read) begin
            if (v_r) begin
              if (produce) begin
                push = hold_v_r;
                hold_v_nxt = 1'b1;
                hold_id_nxt = rd_id_r;
                hold_code_nxt = is_tick_r ? prtq_pkg::OUT_TIMEDOUT : prtq_pkg::OUT_RELEASED;
              end else begin
                we = 1'b1;
                waddr = kept_r[IW-1:0];
                wid = rd_id_r;
                wstamp = rd_stamp_r;
                kept_nxt = kept_r + CW'(1);
              end
            end
            if (!done_read) begin
              re = 1'b1;
              rd_idx_nxt = rd_idx_r + CW'(1);
              v_nxt = 1'b1;
            end else begin
              v_nxt = 1'b0;
            end
          end else begin
            push = hold_v_r;
            push_last = 1'b1;
            hold_v_nxt = 1'b0;
            count_nxt = is_tick_r ? kept_r : '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_task_nxt = out_task_r;
    out_code_nxt = out_code_r;
    out_last_nxt = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_task_nxt = push_id;
      out_code_nxt = push_code;
      out_last_nxt = push_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      v_r <= 1'b0;
      hold_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      v_r <= v_nxt;
      hold_v_r <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    walk_cnt_r <= walk_cnt_nxt;
    rd_idx_r <= rd_idx_nxt;
    kept_r <= kept_nxt;
    is_tick_r <= is_tick_nxt;
    now_r <= now_nxt;
    hold_id_r <= hold_id_nxt;
    hold_code_r <= hold_code_nxt;
    out_task_r <= out_task_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ids_mem[waddr] <= wid;
      stamps_mem[waddr] <= wstamp;
    end
    if (re) begin
      rd_id_r <= ids_mem[raddr];
      rd_stamp_r <= stamps_mem[raddr];
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_task = out_task_r;
  assign out_ch.outcome = out_code_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

`default_nettype wire

@@ hdl/pending_request_timeout_queue.sv @@
// ---------------------------------------------------------------------------
// pending_request_timeout_queue
// Ordered queue of pending task ids with release on wakeup and expiry
// on timer ticks.
// ---------------------------------------------------------------------------
//   Channel   Dir   Handshake              Payload
//   in_ch     in    valid/ready            req_type, task_id, now_time
//   out_ch    out   valid/ready            out_task, outcome, last_of_run
//   cfg       in    APB write/read, 32 b   timeout_limit at byte address 0
//
// A wakeup or tick walks through the stored entries one entry per cycle
// unless the result channel stalls, bound by the single read port of the
// entry store.
// Reset is synchronous and empties the queue; the timeout returns to 5.
// A stalled result channel holds the walk; the two-entry command queue
// keeps accepting requests until it fills.
// ---------------------------------------------------------------------------
`default_nettype none

module pending_request_timeout_queue #(
  parameter int QUEUE_DEPTH = prtq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  prtq_in_if.sink          in_ch,
  prtq_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic           cmd_valid;
  logic           cmd_ready;
  prtq_pkg::cmd_t cmd;
  logic [31:0]    timeout_r, timeout_nxt;

  assign pready = 1'b1;

  always_comb begin
    timeout_nxt = timeout_r;
    if (psel && penable && pwrite && pready && (paddr == prtq_pkg::ADDR_TIMEOUT)) begin
      timeout_nxt = pwdata;
    end
    prdata = (paddr == prtq_pkg::ADDR_TIMEOUT) ? timeout_r : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= prtq_pkg::TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  prtq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  prtq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .timeout_limit (timeout_r),
    .out_ch        (out_ch)
  );

endmodule

`default_nettype wire

@@ verif/tb_pending_request_timeout_queue.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_pending_request_timeout_queue
// Self-checking testbench for the pending request timeout queue. It tracks
// the queued ids and stamps alongside the block, works out the released,
// timed-out and rejected results of every accepted request, and compares
// them in order with the result channel. Both channels idle at random, and
// the timeout is reprogrammed over the APB port between phases.
// ---------------------------------------------------------------------------

module tb_pending_request_timeout_queue;

  localparam int DEPTH = prtq_pkg::QUEUE_DEPTH_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int MAX_GAP = 18;
  localparam int SETTLE_CYCLES = 4 * DEPTH + 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 31;

  typedef struct packed {
    logic [15:0] task_id;
    logic [1:0]  outcome;
    logic        last_of_run;
  } result_t;

  class timeout_queue_tracker;
    logic [31:0] timeout_limit = prtq_pkg::TIMEOUT_RESET;
    logic [15:0] held_ids[$];
    logic [31:0] held_stamps[$];
    result_t     due_results[$];
    int requests = 0;
    int mismatches = 0;
    int released = 0;
    int timed_out = 0;
    int rejected = 0;

    function void add_result(logic [15:0] id, logic [1:0] code);
      result_t r;
      r.task_id = id;
      r.outcome = code;
      r.last_of_run = 1'b0;
      due_results = {due_results, r};
    endfunction

    function void note_request(logic [1:0] kind, logic [15:0] id, logic [31:0] now);
      int first;
      logic [31:0] age;
      logic [15:0] kept_ids[$];
      logic [31:0] kept_stamps[$];
      result_t r;
      first = due_results.size();
      requests++;
      case (kind)
        prtq_pkg::REQ_ADD: begin
          if (held_ids.size() < DEPTH) begin
            held_ids = {held_ids, id};
            held_stamps = {held_stamps, now};
          end else begin
            add_result(id, prtq_pkg::OUT_REJECTED);
          end
        end
        prtq_pkg::REQ_WAKE: begin
          foreach (held_ids[i]) add_result(held_ids[i], prtq_pkg::OUT_RELEASED);
          held_ids.delete();
          held_stamps.delete();
        end
        prtq_pkg::REQ_TICK: begin
          foreach (held_ids[i]) begin
            age = now - held_stamps[i];
            if (age > timeout_limit) begin
              add_result(held_ids[i], prtq_pkg::OUT_TIMEDOUT);
            end else begin
              kept_ids = {kept_ids, held_ids[i]};
              kept_stamps = {kept_stamps, held_stamps[i]};
            end
          end
          held_ids = kept_ids;
          held_stamps = kept_stamps;
        end
        default: ;
      endcase
      if (due_results.size() > first) begin
        r = due_results[$];
        r.last_of_run = 1'b1;
        due_results[$] = r;
      end
    endfunction

    function void check_result(logic [15:0] task_id, logic [1:0] outcome, logic last);
      result_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, task %h outcome %0d last %b",
                 $time, task_id, outcome, last);
        return;
      end
      want = due_results.pop_front();
      if (task_id !== want.task_id) begin
        mismatches++;
        $display("%0t: out_task expected %h, got %h", $time, want.task_id, task_id);
      end
      if (outcome !== want.outcome) begin
        mismatches++;
        $display("%0t: outcome expected %0d, got %0d", $time, want.outcome, outcome);
      end
      if (last !== want.last_of_run) begin
        mismatches++;
        $display("%0t: last_of_run expected %b, got %b", $time, want.last_of_run, last);
      end
      case (want.outcome)
        prtq_pkg::OUT_RELEASED: released++;
        prtq_pkg::OUT_TIMEDOUT: timed_out++;
        default: rejected++;
      endcase
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        take_ready = 1'b0;
  logic        steady_flow = 1'b0;
  logic [31:0] clock_now;
  int          stall_left = 0;
  int          idle_cycles = 0;

  timeout_queue_tracker board;

  prtq_in_if  in_bus ();
  prtq_out_if out_bus ();

  assign out_bus.ready = take_ready;

  pending_request_timeout_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin : result_sink
    int draw;
    if (!rst_n) begin
      take_ready <= 1'b0;
      stall_left <= 0;
    end else if (take_ready) begin
      if (out_bus.valid) begin
        board.check_result(out_bus.out_task, out_bus.outcome, out_bus.last_of_run);
        draw = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
        if (draw != 0) begin
          take_ready <= 1'b0;
          stall_left <= draw;
        end
      end
    end else if (stall_left <= 1) begin
      take_ready <= 1'b1;
      stall_left <= 0;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_pending_request_timeout_queue failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [1:0] kind, input logic [15:0] id,
                              input logic [31:0] now);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.req_type <= kind;
    in_bus.task_id  <= id;
    in_bus.now_time <= now;
    do @(posedge clk); while (!in_bus.ready);
    board.note_request(kind, id, now);
  endtask

  task automatic wait_for_results;
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (board.due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_timeout;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= prtq_pkg::ADDR_TIMEOUT;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== board.timeout_limit) begin
      board.mismatches++;
      $display("%0t: timeout readback expected %h, got %h", $time, board.timeout_limit, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_timeout(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= prtq_pkg::ADDR_TIMEOUT;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.timeout_limit = value;
    read_timeout();
  endtask

  task automatic run_phase(input logic [31:0] limit, input logic [31:0] start_time,
                           input int step_max, input bit pause_midway);
    logic [1:0] kind;
    int pick;
    set_timeout(limit);
    clock_now = start_time;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) kind = prtq_pkg::REQ_ADD;
      else if (pick < 83) kind = prtq_pkg::REQ_TICK;
      else if (pick < 95) kind = prtq_pkg::REQ_WAKE;
      else kind = REQ_UNUSED;
      if ($urandom_range(0, 15) == 0) clock_now = $urandom();
      else clock_now = clock_now + $urandom_range(0, step_max);
      send_request(kind, 16'($urandom_range(0, 16'hFFFF)), clock_now);
      if (pause_midway && n == RANDOM_PER_PHASE / 2) wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin
    board = new();
    rst_n           <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.req_type <= prtq_pkg::REQ_ADD;
    in_bus.task_id  <= 16'h0000;
    in_bus.now_time <= 32'd0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= prtq_pkg::ADDR_TIMEOUT;
    pwdata          <= 32'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_timeout();

    // The entry stamped just before the wrap is one step too old at time 5,
    // while the one stamped at zero has exactly the timeout and survives.
    send_request(prtq_pkg::REQ_TICK, 16'hFFFF, 32'd0);
    send_request(prtq_pkg::REQ_WAKE, 16'h0000, 32'd0);
    send_request(REQ_UNUSED, 16'hABCD, 32'hFFFF_FFFF);
    send_request(prtq_pkg::REQ_ADD, 16'h0000, 32'd0);
    send_request(prtq_pkg::REQ_ADD, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(prtq_pkg::REQ_ADD, 16'h1234, 32'd3);
    send_request(prtq_pkg::REQ_TICK, 16'h0000, 32'd5);
    send_request(prtq_pkg::REQ_TICK, 16'hFFFF, 32'd5);
    send_request(prtq_pkg::REQ_ADD, 16'h5555, 32'd6);
    send_request(prtq_pkg::REQ_TICK, 16'h0000, 32'd6);
    for (int i = 0; i < DEPTH - 2; i++) begin
      send_request(prtq_pkg::REQ_ADD, 16'h0001 << i, 32'd7 + i);
    end
    send_request(prtq_pkg::REQ_ADD, 16'hFFFF, 32'd30);
    send_request(prtq_pkg::REQ_WAKE, 16'h0000, 32'd31);
    wait_for_results();

    run_phase(32'd0, 32'd100, 2, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFF0, 3, 1'b0);
    steady_flow = 1'b1;
    run_phase(32'd12, 32'hFFFF_FFF8, 6, 1'b1);
    steady_flow = 1'b0;
    run_phase($urandom(), $urandom(), 1000, 1'b0);
    run_phase($urandom_range(1, 30), $urandom(), 10, 1'b1);

    $display("Ran %0d requests over the reset timeout, zero, all ones and random settings.",
             board.requests);
    $display("Checked results: %0d released, %0d timed out, %0d rejected.",
             board.released, board.timed_out, board.rejected);
    if (board.mismatches == 0) begin
      $display("tb_pending_request_timeout_queue passed");
    end else begin
      $display("tb_pending_request_timeout_queue failed");
    end
    $finish;
  end

endmodule
